// ===== hdl/ucf_pkg.sv =====
// ----------------------------------------------------------------------------
// ucf_pkg
// shared types and constants of the undirected cycle finder
// ----------------------------------------------------------------------------
package ucf_pkg;

    // fixed field widths
    localparam int NODE_W = 6;
    localparam int OP_W   = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd2;

    // one result word
    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] cycle_node;
        logic [NODE_W-1:0] list_length;
        logic              dropped_edges;
        logic              last;
    } ucf_result_t;

endpackage

// ===== hdl/ucf_out_stage.sv =====
// ----------------------------------------------------------------------------
// ucf_out_stage
// result output register with valid / stall handshake
// ----------------------------------------------------------------------------
module ucf_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ucf_pkg::ucf_result_t word_in,
    output logic                free,
    output logic                out_valid,
    input  logic                out_stall,
    output ucf_pkg::ucf_result_t word_out
);
    import ucf_pkg::*;

    logic        valid_reg;
    ucf_result_t word_reg;

    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign word_out  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    // payload only moves when the slot is free
    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            word_reg <= word_in;
        end
    end

endmodule

// ===== hdl/undirected_cycle_finder_top.sv =====
// ----------------------------------------------------------------------------
// undirected_cycle_finder_top
// edge store plus memory based depth-first search for a cycle
// ----------------------------------------------------------------------------
// clear and add-edge words are taken back to back
// a find word holds in_stall high until its last result word is loaded
// into the output register;
// each edge position is an edge memory read, then an evaluate; each stack pop is a
// stack memory read, then a top reload; each root is a check; each walk step is a
// parent read, then a check; a result word is a list read, then a load held while the output is stalled
// rst_n clears control, edge count, drop flag and sets node_count to 32
module undirected_cycle_finder_top #(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // command channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ucf_pkg::OP_W-1:0]   op,
    input  logic [ucf_pkg::NODE_W-1:0] node_a,
    input  logic [ucf_pkg::NODE_W-1:0] node_b,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       found,
    output logic [ucf_pkg::NODE_W-1:0] cycle_node,
    output logic [ucf_pkg::NODE_W-1:0] list_length,
    output logic                       dropped_edges,
    output logic                       last,
    // node count register write
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ucf_pkg::NODE_W-1:0] node_count
);
    import ucf_pkg::*;

    // sizes
    localparam int NA   = $clog2(MAX_NODES + 1);          // node table index
    localparam int SPW  = $clog2(MAX_NODES + 2);          // stack / list count
    localparam int ETW  = $clog2(MAX_EDGES + 1);          // edge count
    localparam int PW   = ETW + 1;                        // neighbour position
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW   = 2 * NODE_W;                     // packed edge
    localparam int SW   = 2 * NODE_W + PW;                // stack entry
    localparam int RW   = NODE_W + 1;                     // root counter

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ROOT = 4'd1;
    localparam logic [3:0] S_STEP = 4'd2;
    localparam logic [3:0] S_POPW = 4'd3;
    localparam logic [3:0] S_EVAL = 4'd4;
    localparam logic [3:0] S_FCHK = 4'd5;
    localparam logic [3:0] S_FFIX = 4'd6;
    localparam logic [3:0] S_WRD  = 4'd7;
    localparam logic [3:0] S_WCHK = 4'd8;
    localparam logic [3:0] S_WEND = 4'd9;
    localparam logic [3:0] S_EMRD = 4'd10;
    localparam logic [3:0] S_EMLD = 4'd11;
    localparam logic [3:0] S_NONE = 4'd12;

    localparam logic [NODE_W-1:0] MAXN   = NODE_W'(MAX_NODES);
    localparam logic [ETW-1:0]    MAXE   = ETW'(MAX_EDGES);
    localparam logic [SPW-1:0]    STKTOP = SPW'(MAX_NODES + 1);
    localparam logic [SPW-1:0]    LSTMAX = SPW'(MAX_NODES);

    // ---------------------------------------------------------------- memories
    logic [EW-1:0]     edge_mem   [MAX_EDGES];
    logic [SW-1:0]     stack_mem  [MAX_NODES + 1];
    logic [NODE_W-1:0] parent_mem [MAX_NODES + 1];
    logic [NODE_W-1:0] list_mem   [MAX_NODES + 1];

    logic [EW-1:0]     edge_rd_reg;
    logic [SW-1:0]     stack_rd_reg;
    logic [NODE_W-1:0] parent_rd_reg;
    logic [NODE_W-1:0] list_rd_reg;

    // memory port controls
    logic              edge_we,   edge_re;
    logic [EAW-1:0]    edge_waddr, edge_raddr;
    logic              stack_we,  stack_re;
    logic [NA-1:0]     stack_waddr, stack_raddr;
    logic [SW-1:0]     stack_wdata;
    logic              parent_we, parent_re;
    logic [NA-1:0]     parent_waddr, parent_raddr;
    logic [NODE_W-1:0] parent_wdata;
    logic              list_we,   list_re;
    logic [NA-1:0]     list_waddr, list_raddr;
    logic [NODE_W-1:0] list_wdata;

    // ---------------------------------------------------------------- state
    logic [3:0]           state_reg,      state_next;
    logic [ETW-1:0]       edge_total_reg, edge_total_next;
    logic                 ovf_reg,        ovf_next;
    logic [NODE_W-1:0]    node_count_reg;
    logic [MAX_NODES:0]   visited_reg,    visited_next;
    logic [RW-1:0]        root_reg,       root_next;
    logic [SPW-1:0]       sp_reg,         sp_next;
    logic [NODE_W-1:0]    top_node_reg,   top_node_next;
    logic [PW-1:0]        top_pos_reg,    top_pos_next;
    logic [NODE_W-1:0]    top_par_reg,    top_par_next;
    logic                 odd_reg,        odd_next;
    logic [NODE_W-1:0]    cu_reg,         cu_next;
    logic [NODE_W-1:0]    cv_reg,         cv_next;
    logic [NODE_W-1:0]    cur_reg,        cur_next;
    logic [SPW-1:0]       n_reg,          n_next;
    logic [SPW-1:0]       k_reg,          k_next;

    // output stage hookup
    logic        out_load;
    logic        out_free;
    ucf_result_t out_word;
    ucf_result_t out_bus;

    // helpers
    logic [NODE_W-1:0] roots;
    logic [PW-1:0]     limit;
    logic [NODE_W-1:0] ea, eb, nb;
    logic              nb_match;
    logic              nb_ok;
    logic              in_acc;
    logic [NODE_W-1:0] pnode;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign roots = (node_count_reg > MAXN) ? MAXN : node_count_reg;
    assign limit = {edge_total_reg, 1'b0};

    // neighbour offered by the edge just read: even position offers b to a,
    // odd position offers a to b
    assign ea       = edge_rd_reg[NODE_W-1:0];
    assign eb       = edge_rd_reg[EW-1:NODE_W];
    assign nb       = odd_reg ? ea : eb;
    assign nb_match = odd_reg ? (eb == top_node_reg) : (ea == top_node_reg);
    assign nb_ok    = nb_match && (nb != '0) && (nb <= MAXN) && (nb != top_par_reg);

    assign pnode = parent_rd_reg;

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        ovf_next        = ovf_reg;
        visited_next    = visited_reg;
        root_next       = root_reg;
        sp_next         = sp_reg;
        top_node_next   = top_node_reg;
        top_pos_next    = top_pos_reg;
        top_par_next    = top_par_reg;
        odd_next        = odd_reg;
        cu_next         = cu_reg;
        cv_next         = cv_reg;
        cur_next        = cur_reg;
        n_next          = n_reg;
        k_next          = k_reg;

        edge_we      = 1'b0;
        edge_waddr   = edge_total_reg[EAW-1:0];
        edge_re      = 1'b0;
        edge_raddr   = top_pos_reg[EAW:1];
        stack_we     = 1'b0;
        stack_waddr  = NA'(sp_reg - 1'b1);
        stack_wdata  = {top_par_reg, top_node_reg, top_pos_reg};
        stack_re     = 1'b0;
        stack_raddr  = NA'(sp_reg - 2'd2);
        parent_we    = 1'b0;
        parent_waddr = root_reg[NA-1:0];
        parent_wdata = '0;
        parent_re    = 1'b0;
        parent_raddr = cur_reg[NA-1:0];
        list_we      = 1'b0;
        list_waddr   = n_reg[NA-1:0];
        list_wdata   = cu_reg;
        list_re      = 1'b0;
        list_raddr   = k_reg[NA-1:0];

        out_load = 1'b0;
        out_word = '{found: 1'b0, cycle_node: '0, list_length: '0,
                     dropped_edges: ovf_reg, last: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (op)
                        OP_CLEAR:
                        begin
                            edge_total_next = '0;
                            ovf_next        = 1'b0;
                        end
                        OP_ADD:
                        begin
                            if ((node_a == '0) || (node_b == '0) || (node_a > MAXN) ||
                                (node_b > MAXN) || (edge_total_reg >= MAXE))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                edge_we         = 1'b1;
                                edge_total_next = edge_total_reg + 1'b1;
                            end
                        end
                        OP_FIND:
                        begin
                            visited_next = '0;
                            root_next    = RW'(1);
                            state_next   = S_ROOT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // pick the next unvisited root
            S_ROOT:
            begin
                if (root_reg > {1'b0, roots})
                begin
                    state_next = S_NONE;
                end
                else if (visited_reg[root_reg[NA-1:0]])
                begin
                    root_next = root_reg + 1'b1;
                end
                else
                begin
                    visited_next[root_reg[NA-1:0]] = 1'b1;
                    parent_we     = 1'b1;
                    parent_waddr  = root_reg[NA-1:0];
                    parent_wdata  = '0;
                    top_node_next = root_reg[NODE_W-1:0];
                    top_pos_next  = '0;
                    top_par_next  = '0;
                    sp_next       = SPW'(1);
                    state_next    = S_STEP;
                end
            end

            // advance the top of stack by one neighbour position, or pop it when its positions are used up
            S_STEP:
            begin
                if (top_pos_reg >= limit)
                begin
                    if (sp_reg == SPW'(1))
                    begin
                        root_next  = root_reg + 1'b1;
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        stack_re   = 1'b1;
                        sp_next    = sp_reg - 1'b1;
                        state_next = S_POPW;
                    end
                end
                else
                begin
                    edge_re      = 1'b1;
                    odd_next     = top_pos_reg[0];
                    top_pos_next = top_pos_reg + 1'b1;
                    state_next   = S_EVAL;
                end
            end

            S_POPW:
            begin
                top_pos_next  = stack_rd_reg[PW-1:0];
                top_node_next = stack_rd_reg[PW +: NODE_W];
                top_par_next  = stack_rd_reg[PW + NODE_W +: NODE_W];
                state_next    = S_STEP;
            end

            S_EVAL:
            begin
                state_next = S_STEP;
                if (nb_ok)
                begin
                    if (!visited_reg[nb[NA-1:0]])
                    begin
                        visited_next[nb[NA-1:0]] = 1'b1;
                        parent_we    = 1'b1;
                        parent_waddr = nb[NA-1:0];
                        parent_wdata = top_node_reg;
                        if (sp_reg < STKTOP)
                        begin
                            stack_we      = 1'b1;
                            top_node_next = nb;
                            top_pos_next  = '0;
                            top_par_next  = top_node_reg;
                            sp_next       = sp_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        // cycle closed: list starts with the current node
                        cu_next    = top_node_reg;
                        cv_next    = nb;
                        list_we    = 1'b1;
                        list_waddr = '0;
                        list_wdata = top_node_reg;
                        n_next     = SPW'(1);
                        state_next = S_FCHK;
                    end
                end
            end

            S_FCHK:
            begin
                parent_re    = 1'b1;
                parent_raddr = cv_reg[NA-1:0];
                state_next   = S_FFIX;
            end

            S_FFIX:
            begin
                if ((cv_reg != cu_reg) && (pnode == cu_reg))
                begin
                    // another edge to a tree child
                    list_we    = 1'b1;
                    list_waddr = n_reg[NA-1:0];
                    list_wdata = cv_reg;
                    n_next     = n_reg + 1'b1;
                    state_next = S_WEND;
                end
                else
                begin
                    parent_we    = 1'b1;
                    parent_waddr = cv_reg[NA-1:0];
                    parent_wdata = cu_reg;
                    cur_next     = cu_reg;
                    state_next   = S_WRD;
                end
            end

            // follow parent links back to the current node
            S_WRD:
            begin
                parent_re    = 1'b1;
                parent_raddr = cur_reg[NA-1:0];
                state_next   = S_WCHK;
            end

            S_WCHK:
            begin
                if ((pnode == cu_reg) || (n_reg >= LSTMAX) ||
                    (pnode == '0) || (pnode > MAXN))
                begin
                    state_next = S_WEND;
                end
                else
                begin
                    list_we    = 1'b1;
                    list_waddr = n_reg[NA-1:0];
                    list_wdata = pnode;
                    n_next     = n_reg + 1'b1;
                    cur_next   = pnode;
                    state_next = S_WRD;
                end
            end

            S_WEND:
            begin
                list_we    = 1'b1;
                list_waddr = n_reg[NA-1:0];
                list_wdata = cu_reg;
                n_next     = n_reg + 1'b1;
                k_next     = '0;
                state_next = S_EMRD;
            end

            S_EMRD:
            begin
                list_re    = 1'b1;
                list_raddr = k_reg[NA-1:0];
                state_next = S_EMLD;
            end

            S_EMLD:
            begin
                out_word = '{found: 1'b1, cycle_node: list_rd_reg,
                             list_length: NODE_W'(n_reg), dropped_edges: ovf_reg,
                             last: (k_reg == n_reg - 1'b1)};
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (k_reg == n_reg - 1'b1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_EMRD;
                    end
                end
            end

            S_NONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_total_reg <= '0;
            ovf_reg        <= 1'b0;
            node_count_reg <= NODE_W'(32);
            visited_reg    <= '0;
            root_reg       <= '0;
            sp_reg         <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            ovf_reg        <= ovf_next;
            visited_reg    <= visited_next;
            root_reg       <= root_next;
            sp_reg         <= sp_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= node_count;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        top_node_reg <= top_node_next;
        top_pos_reg  <= top_pos_next;
        top_par_reg  <= top_par_next;
        odd_reg      <= odd_next;
        cu_reg       <= cu_next;
        cv_reg       <= cv_next;
        cur_reg      <= cur_next;
    end

    // edge memory
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= {node_b, node_a};
        end
        if (edge_re)
        begin
            edge_rd_reg <= edge_mem[edge_raddr];
        end
    end

    // stack memory, entries below the cached top
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_re)
        begin
            stack_rd_reg <= stack_mem[stack_raddr];
        end
    end

    // search parent memory, written whenever a node is marked visited
    always_ff @(posedge clk)
    begin
        if (parent_we)
        begin
            parent_mem[parent_waddr] <= parent_wdata;
        end
        if (parent_re)
        begin
            parent_rd_reg <= parent_mem[parent_raddr];
        end
    end

    // cycle list buffer
    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_waddr] <= list_wdata;
        end
        if (list_re)
        begin
            list_rd_reg <= list_mem[list_raddr];
        end
    end

    // ---------------------------------------------------------------- output
    ucf_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .word_in   (out_word),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .word_out  (out_bus)
    );

    assign found         = out_bus.found;
    assign cycle_node    = out_bus.cycle_node;
    assign list_length   = out_bus.list_length;
    assign dropped_edges = out_bus.dropped_edges;
    assign last          = out_bus.last;

endmodule

// ===== hdl/ucf_checker.sv =====
// ----------------------------------------------------------------------------
// ucf_checker
// port level checks of the undirected cycle finder
// ----------------------------------------------------------------------------
module ucf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       found,
    input logic [ucf_pkg::NODE_W-1:0] cycle_node,
    input logic [ucf_pkg::NODE_W-1:0] list_length,
    input logic                       last
);
    import ucf_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cycle_node) && $stable(last))
        else $error("result word changed while stalled");

    // no command taken in the middle of a cycle list
    a_busy_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("command accepted during cycle list");

    // a not-found word stands alone and carries no node
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (cycle_node == '0) && (list_length == '0) && last)
        else $error("bad not-found word");

    // a cycle list names a real node and is never one entry long
    a_found_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> (cycle_node != '0) && (list_length != NODE_W'(1)))
        else $error("bad cycle word");

endmodule

bind undirected_cycle_finder_top ucf_checker u_ucf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .cycle_node  (cycle_node),
    .list_length (list_length),
    .last        (last)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for undirected_cycle_finder_top: edge loads and find
// requests are mirrored by a behavioral depth-first search whose expected
// result words are compared field by field with every word the block emits
// ----------------------------------------------------------------------------
module tb;
    import ucf_pkg::*;

    // op code the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int NODES = 32;
    localparam int EDGES = 64;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              out_valid;
    logic              out_stall;
    logic              found;
    logic [NODE_W-1:0] cycle_node;
    logic [NODE_W-1:0] list_length;
    logic              dropped_edges;
    logic              last;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [NODE_W-1:0] node_count;

    undirected_cycle_finder_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .node_a       (node_a),
        .node_b       (node_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .cycle_node   (cycle_node),
        .list_length  (list_length),
        .dropped_edges(dropped_edges),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .node_count   (node_count)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // mirror of the block state
    // ------------------------------------------------------------------
    logic [NODE_W-1:0] graph_a [EDGES];
    logic [NODE_W-1:0] graph_b [EDGES];
    int                graph_edges;
    logic              graph_dropped;
    logic [NODE_W-1:0] count_reg;

    // expected result words, oldest first
    ucf_result_t cycle_words_q[$];

    int err_count;
    int src_idle_pct;   // sender idle chance per cycle, percent
    int dst_stall_pct;  // receiver stall chance per cycle, percent

    function automatic void push_word(logic f, int nd, int len, logic lst);
        ucf_result_t w;
        w.found         = f;
        w.cycle_node    = nd[NODE_W-1:0];
        w.list_length   = len[NODE_W-1:0];
        w.dropped_edges = graph_dropped;
        w.last          = lst;
        cycle_words_q.insert(cycle_words_q.size(), w);
    endfunction

    // depth-first search over the mirrored graph, queues the emitted walk
    function automatic void predict_cycle();
        logic visited [NODES+1];
        int   parent  [NODES+1];
        int   stk_nd  [NODES+1];
        int   stk_pos [NODES+1];
        int   walk    [NODES+1];
        int   roots, sp, u, v, pos, lim, cu, cv, n, cur;
        logic hit;
        for (int i = 0; i <= NODES; i++)
        begin
            visited[i] = 1'b0;
            parent[i]  = 0;
        end
        // counts above the node range act as the full range
        roots = (count_reg > NODES) ? NODES : count_reg;
        hit   = 1'b0;
        cu    = 0;
        cv    = 0;
        lim   = 2 * graph_edges;
        for (int r = 1; r <= roots && !hit; r++)
        begin
            if (visited[r])
                continue;
            visited[r] = 1'b1;
            parent[r]  = 0;
            sp         = 1;
            stk_nd[0]  = r;
            stk_pos[0] = 0;
            while (sp > 0 && !hit)
            begin
                u   = stk_nd[sp-1];
                pos = stk_pos[sp-1];
                if (pos >= lim)
                begin
                    sp--;
                    continue;
                end
                stk_pos[sp-1] = pos + 1;
                // even position offers b to a, odd offers a to b
                if (pos % 2 == 0)
                begin
                    if (graph_a[pos/2] != u)
                        continue;
                    v = graph_b[pos/2];
                end
                else
                begin
                    if (graph_b[pos/2] != u)
                        continue;
                    v = graph_a[pos/2];
                end
                if (v == 0 || v > NODES || v == parent[u])
                    continue;
                if (!visited[v])
                begin
                    visited[v] = 1'b1;
                    parent[v]  = u;
                    if (sp < NODES + 1)
                    begin
                        stk_nd[sp]  = v;
                        stk_pos[sp] = 0;
                        sp++;
                    end
                end
                else
                begin
                    hit = 1'b1;
                    cu  = u;
                    cv  = v;
                end
            end
        end
        if (!hit)
        begin
            push_word(1'b0, 0, 0, 1'b1);
            return;
        end
        n = 0;
        walk[n++] = cu;
        if (cv != cu && parent[cv] == cu)
            // another edge to a tree child
            walk[n++] = cv;
        else
        begin
            parent[cv] = cu;
            cur = cu;
            while (parent[cur] != cu && n < NODES)
            begin
                cur = parent[cur];
                if (cur == 0 || cur > NODES)
                    break;
                walk[n++] = cur;
            end
        end
        walk[n++] = cu;
        for (int k = 0; k < n; k++)
            push_word(1'b1, walk[k], n, k == n - 1);
    endfunction

    function automatic void apply_word(logic [OP_W-1:0] o, logic [NODE_W-1:0] a,
                                       logic [NODE_W-1:0] b);
        case (o)
            OP_CLEAR:
            begin
                graph_edges   = 0;
                graph_dropped = 1'b0;
            end
            OP_ADD:
            begin
                if (a == 0 || b == 0 || a > NODES || b > NODES || graph_edges >= EDGES)
                    graph_dropped = 1'b1;
                else
                begin
                    graph_a[graph_edges] = a;
                    graph_b[graph_edges] = b;
                    graph_edges++;
                end
            end
            OP_FIND:
                predict_cycle();
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // command channel
    // ------------------------------------------------------------------
    task automatic send_word(input logic [OP_W-1:0] o, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b);
        // optional idle gap before the word
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        in_valid <= 1'b1;
        op       <= o;
        node_a   <= a;
        node_b   <= b;
        do
            @(posedge clk);
        while (in_stall);
        apply_word(o, a, b);
    endtask

    // let every expected word arrive, then a short settle
    task automatic drain();
        in_valid <= 1'b0;
        while (cycle_words_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_node_count(input logic [NODE_W-1:0] v);
        drain();
        cfg_valid  <= 1'b1;
        node_count <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_reg  = v;
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (dst_stall_pct != 0)
            out_stall <= ($urandom_range(99) < dst_stall_pct);
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        ucf_result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cycle_words_q.size() == 0)
            begin
                $display("%0t unexpected word: found %0d node %0d len %0d drop %0d last %0d",
                         $time, found, cycle_node, list_length, dropped_edges, last);
                err_count++;
            end
            else
            begin
                w = cycle_words_q.pop_front();
                if (w.found !== found)
                begin
                    $display("%0t found: expected %0d actual %0d", $time, w.found, found);
                    err_count++;
                end
                if (w.cycle_node !== cycle_node)
                begin
                    $display("%0t cycle_node: expected %0d actual %0d", $time,
                             w.cycle_node, cycle_node);
                    err_count++;
                end
                if (w.list_length !== list_length)
                begin
                    $display("%0t list_length: expected %0d actual %0d", $time,
                             w.list_length, list_length);
                    err_count++;
                end
                if (w.dropped_edges !== dropped_edges)
                begin
                    $display("%0t dropped_edges: expected %0d actual %0d", $time,
                             w.dropped_edges, dropped_edges);
                    err_count++;
                end
                if (w.last !== last)
                begin
                    $display("%0t last: expected %0d actual %0d", $time, w.last, last);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // triangle, self loop, parallel edge, bad ids, ignored op, empty graph, tree, repeated find
    task automatic test_special_graphs();
        send_word(OP_CLEAR, 6'd0, 6'd0);
        send_word(OP_FIND, 6'd0, 6'd0);            // empty graph, no cycle
        send_word(OP_ADD, 6'd1, 6'd2);
        send_word(OP_ADD, 6'd2, 6'd3);
        send_word(OP_ADD, 6'd3, 6'd1);
        send_word(OP_FIND, 6'd0, 6'd0);            // triangle
        send_word(OP_CLEAR, 6'd63, 6'd63);
        send_word(OP_ADD, 6'd32, 6'd32);           // self loop on top node
        send_word(OP_FIND, 6'd0, 6'd0);
        send_word(OP_CLEAR, 6'd0, 6'd0);
        send_word(OP_ADD, 6'd4, 6'd5);
        send_word(OP_ADD, 6'd5, 6'd4);             // parallel edge
        send_word(OP_FIND, 6'd0, 6'd0);
        send_word(OP_ADD, 6'd0, 6'd3);             // bad endpoints drop
        send_word(OP_ADD, 6'd33, 6'd1);
        send_word(OP_ADD, 6'd1, 6'd63);
        send_word(OP_UNUSED, 6'd21, 6'd42);        // ignored
        send_word(OP_FIND, 6'd0, 6'd0);
        send_word(OP_CLEAR, 6'd0, 6'd0);
        send_word(OP_ADD, 6'd1, 6'd2);             // tree, no cycle
        send_word(OP_ADD, 6'd2, 6'd3);
        send_word(OP_FIND, 6'd0, 6'd0);
        send_word(OP_FIND, 6'd0, 6'd0);            // repeated find
        drain();
    endtask

    // register extremes: zero roots, out of range count, reach above count
    task automatic test_node_count();
        write_node_count(6'd0);
        send_word(OP_FIND, 6'd0, 6'd0);
        write_node_count(6'd63);
        send_word(OP_ADD, 6'd30, 6'd31);
        send_word(OP_ADD, 6'd31, 6'd30);
        send_word(OP_FIND, 6'd0, 6'd0);
        write_node_count(6'd1);
        send_word(OP_CLEAR, 6'd0, 6'd0);
        send_word(OP_ADD, 6'd1, 6'd9);             // nodes beyond the count
        send_word(OP_ADD, 6'd9, 6'd10);
        send_word(OP_ADD, 6'd10, 6'd1);
        send_word(OP_FIND, 6'd0, 6'd0);
        write_node_count(6'd32);
    endtask

    // store overflow: fill past capacity
    task automatic test_store_full();
        send_word(OP_CLEAR, 6'd0, 6'd0);
        for (int i = 0; i < EDGES + 2; i++)
            send_word(OP_ADD, 6'(1 + i % 31), 6'(2 + i % 31));
        send_word(OP_FIND, 6'd0, 6'd0);
        send_word(OP_CLEAR, 6'd0, 6'd0);
        send_word(OP_FIND, 6'd0, 6'd0);            // drop flag cleared
        drain();
    endtask

    // random graphs: mostly clear / edges / find, with noise mixed in
    task automatic test_random_graphs(input int graphs);
        int span, k;
        logic [NODE_W-1:0] a, b;
        for (int g = 0; g < graphs; g++)
        begin
            span = ($urandom_range(3) == 0) ? $urandom_range(2, 32) : $urandom_range(2, 8);
            k    = $urandom_range(1, 12);
            send_word(OP_CLEAR, 6'($urandom), 6'($urandom));
            for (int e = 0; e < k; e++)
            begin
                if ($urandom_range(1) == 0 && e + 1 < span)
                begin
                    // tree edge keeps some graphs acyclic
                    a = 6'(e + 2);
                    b = 6'($urandom_range(1, e + 1));
                end
                else
                begin
                    a = 6'($urandom_range(1, span));
                    b = 6'($urandom_range(1, span));
                end
                case ($urandom_range(19))
                    0:       send_word(OP_ADD, 6'($urandom), 6'($urandom));
                    1:       send_word(OP_UNUSED, 6'($urandom), 6'($urandom));
                    2:       send_word(OP_FIND, 6'($urandom), 6'($urandom));
                    default: send_word(OP_ADD, a, b);
                endcase
            end
            send_word(OP_FIND, 6'($urandom), 6'($urandom));
        end
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_CLEAR;
        node_a        = '0;
        node_b        = '0;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        node_count    = '0;
        err_count     = 0;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        graph_edges   = 0;
        graph_dropped = 1'b0;
        count_reg     = 6'd32;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_graphs();
        test_node_count();
        test_store_full();

        // idle phases: none, sender, receiver, both
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct  = (ph == 1) ? 64 : (ph == 3) ? 18 : 0;
            dst_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 18 : 0;
            write_node_count(6'($urandom_range(1, 32)));
            test_random_graphs(5);
            write_node_count(6'd32);
            test_random_graphs(5);
        end
        test_special_graphs();

        drain();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ucf_pkg.sv
hdl/ucf_out_stage.sv
hdl/undirected_cycle_finder_top.sv
hdl/ucf_checker.sv
tb/tb.sv
